### rtl/core/hlx_pkg.sv
// Shared types and codes of the header/length/XOR frame parser.
package hlx_pkg;

    localparam int unsigned ByteW = 8;

    typedef enum logic [2:0] {
        ROLE_DISCARD = 3'd0,
        ROLE_HEADER  = 3'd1,
        ROLE_LENGTH  = 3'd2,
        ROLE_BODY    = 3'd3,
        ROLE_CHECK   = 3'd4
    } role_t;

    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_OK     = 2'd1,
        ST_BADSUM = 2'd2,
        ST_BADLEN = 2'd3
    } status_t;

    // Register indexes of the configuration port
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_MAXLEN = 1'b1;

    typedef struct packed {
        logic [ByteW-1:0] data;
        role_t            role;
        status_t          status;
        logic             last;
    } result_t;

endpackage

### rtl/core/hlx_in_stage.sv
// Input register stage of the frame parser.
module hlx_in_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [hlx_pkg::ByteW-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic                       advance,
    output logic                       in_valid,
    output logic [hlx_pkg::ByteW-1:0]  in_byte
);

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [hlx_pkg::ByteW-1:0] in_byte_reg;

    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_byte  = in_byte_reg;

endmodule

### rtl/core/hlx_parser.sv
// Frame parsing state and per-byte decode.
module hlx_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [hlx_pkg::ByteW-1:0]  in_byte,
    input  logic [hlx_pkg::ByteW-1:0]  header_byte,
    input  logic [hlx_pkg::ByteW-1:0]  max_length,
    output hlx_pkg::result_t           result
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    phase_t                    phase_reg;
    phase_t                    phase_next;
    logic [hlx_pkg::ByteW-1:0] left_reg;
    logic [hlx_pkg::ByteW-1:0] left_next;
    logic [hlx_pkg::ByteW-1:0] xor_reg;
    logic [hlx_pkg::ByteW-1:0] xor_next;
    logic [hlx_pkg::ByteW-1:0] left_dec;
    logic                      is_header;

    assign is_header = (in_byte == header_byte);
    assign left_dec  = (left_reg != '0) ? (left_reg - 1'b1) : left_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        left_next     = left_reg;
        xor_next      = xor_reg;
        result.data   = in_byte;
        result.role   = hlx_pkg::ROLE_DISCARD;
        result.status = hlx_pkg::ST_BUSY;
        result.last   = 1'b0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (is_header)
                begin
                    result.role = hlx_pkg::ROLE_HEADER;
                    xor_next    = in_byte;
                    phase_next  = PH_LEN;
                end
            end
            PH_LEN:
            begin
                result.role = hlx_pkg::ROLE_LENGTH;
                if (in_byte > max_length)
                begin
                    // reject, then rescan this byte as a possible header
                    result.status = hlx_pkg::ST_BADLEN;
                    result.last   = 1'b1;
                    left_next     = '0;
                    if (is_header)
                    begin
                        xor_next   = in_byte;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        xor_next   = '0;
                        phase_next = PH_HUNT;
                    end
                end
                else
                begin
                    xor_next   = xor_reg ^ in_byte;
                    left_next  = in_byte;
                    phase_next = (in_byte != '0) ? PH_BODY : PH_SUM;
                end
            end
            PH_BODY:
            begin
                result.role = hlx_pkg::ROLE_BODY;
                xor_next    = xor_reg ^ in_byte;
                left_next   = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                result.role   = hlx_pkg::ROLE_CHECK;
                result.status = (in_byte == xor_reg) ? hlx_pkg::ST_OK : hlx_pkg::ST_BADSUM;
                result.last   = 1'b1;
                xor_next      = '0;
                left_next     = '0;
                phase_next    = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            left_reg  <= '0;
            xor_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

### rtl/core/header_length_xor_frame_parser_unit.sv
// Top level of the header/length/XOR frame parser with its register port.
//
// Each received byte on the input stream yields exactly one result on the output
// stream, carrying the byte, its role in the frame and the frame status; tlast
// marks the byte that ends or aborts a frame. The block takes one byte per cycle
// while the output is not stalled; each byte is held first in the input register,
// then as a result in the result register, with the frame state stepped as
// a byte moves between them. Input ready follows output ready through those two
// registers, so a stall downstream holds the input once both are full.
// Configuration (header byte at 0x0, maximum length at 0x4) applies from the
// next byte parsed.
module header_length_xor_frame_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]  m_axis_tuser,   // [2:0] byte_role, [4:3] frame_status
    output logic        m_axis_tlast,   // frame_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [hlx_pkg::ByteW-1:0] header_reg;
    logic [hlx_pkg::ByteW-1:0] maxlen_reg;
    logic                      cfg_write;

    logic                      in_valid;
    logic [hlx_pkg::ByteW-1:0] in_byte;
    logic                      advance;
    hlx_pkg::result_t          result;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    hlx_pkg::result_t          out_reg;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= 8'h00;
            maxlen_reg <= 8'hFF;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == hlx_pkg::REG_HEADER)
            begin
                header_reg <= pwdata[hlx_pkg::ByteW-1:0];
            end
            else
            begin
                maxlen_reg <= pwdata[hlx_pkg::ByteW-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == hlx_pkg::REG_MAXLEN)
        begin
            prdata[hlx_pkg::ByteW-1:0] = maxlen_reg;
        end
        else
        begin
            prdata[hlx_pkg::ByteW-1:0] = header_reg;
        end
    end

    // Step a byte into the result register whenever that register is free or draining
    assign advance = in_valid && (!out_valid_reg || m_axis_tready);

    hlx_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .in_valid      (in_valid),
        .in_byte       (in_byte)
    );

    hlx_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_byte     (in_byte),
        .header_byte (header_reg),
        .max_length  (maxlen_reg),
        .result      (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.data;
    assign m_axis_tuser  = {out_reg.status, out_reg.role};
    assign m_axis_tlast  = out_reg.last;

    // A checksum byte always closes its frame
    a_check_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2:0] == hlx_pkg::ROLE_CHECK) |-> m_axis_tlast)
        else $error("checksum byte without tlast");

    // A rejected length is reported only on a length byte, and closes the frame
    a_badlen_role: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[4:3] == hlx_pkg::ST_BADLEN)
        |-> (m_axis_tuser[2:0] == hlx_pkg::ROLE_LENGTH && m_axis_tlast))
        else $error("length rejection on a non-length byte");

    // Discarded bytes carry no status and never end a frame
    a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2:0] == hlx_pkg::ROLE_DISCARD)
        |-> (m_axis_tuser[4:3] == hlx_pkg::ST_BUSY && !m_axis_tlast))
        else $error("discarded byte with status or tlast");

    // A byte held in the input stage while output drains must move on
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && m_axis_tready) |=> m_axis_tvalid)
        else $error("result lost between stages");

endmodule

### dv/testbench.sv
// Self-checking stream testbench for the header/length/XOR frame parser.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 400000;

    typedef enum logic [1:0] {
        PH_HUNT     = 2'd0,
        PH_WANT_LEN = 2'd1,
        PH_IN_BODY  = 2'd2,
        PH_WANT_SUM = 2'd3
    } parse_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] out_byte
    logic [4:0]  m_axis_tuser;         // [2:0] byte_role, [4:3] frame_status
    logic        m_axis_tlast;         // frame_last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    header_length_xor_frame_parser_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Parser state and register copies
    logic [7:0]   cfg_header = 8'h00;
    logic [7:0]   cfg_max_len = 8'hFF;
    parse_phase_t phase_q = PH_HUNT;
    logic [7:0]   body_left = 8'h00;
    logic [7:0]   frame_xor = 8'h00;

    hlx_pkg::result_t pending_results[$];
    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_checked = 0;
    int unsigned frames_ok = 0;
    int unsigned frames_bad_sum = 0;
    int unsigned lengths_rejected = 0;
    int unsigned settings_applied = 0;
    int unsigned cycle_count = 0;
    int unsigned ready_hold = 0;
    bit          src_gaps = 1'b0;
    bit          sink_stalls = 1'b0;

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_results.size());
        $display("testbench NOT OK");
        $finish;
    end

    function automatic hlx_pkg::result_t parse_byte(input logic [7:0] b);
        hlx_pkg::result_t r;
        r.data   = b;
        r.role   = hlx_pkg::ROLE_DISCARD;
        r.status = hlx_pkg::ST_BUSY;
        r.last   = 1'b0;
        case (phase_q)
            PH_HUNT:
            begin
                if (b == cfg_header)
                begin
                    r.role    = hlx_pkg::ROLE_HEADER;
                    frame_xor = b;
                    phase_q   = PH_WANT_LEN;
                end
            end
            PH_WANT_LEN:
            begin
                r.role = hlx_pkg::ROLE_LENGTH;
                if (b > cfg_max_len)
                begin
                    r.status  = hlx_pkg::ST_BADLEN;
                    r.last    = 1'b1;
                    body_left = 8'h00;
                    // Rescan the rejected length as a possible header
                    if (b == cfg_header)
                    begin
                        frame_xor = b;
                        phase_q   = PH_WANT_LEN;
                    end
                    else
                    begin
                        frame_xor = 8'h00;
                        phase_q   = PH_HUNT;
                    end
                end
                else
                begin
                    frame_xor = frame_xor ^ b;
                    body_left = b;
                    phase_q   = (b != 8'h00) ? PH_IN_BODY : PH_WANT_SUM;
                end
            end
            PH_IN_BODY:
            begin
                r.role    = hlx_pkg::ROLE_BODY;
                frame_xor = frame_xor ^ b;
                if (body_left != 8'h00)
                    body_left = body_left - 8'h01;
                if (body_left == 8'h00)
                    phase_q = PH_WANT_SUM;
            end
            default:
            begin
                r.role    = hlx_pkg::ROLE_CHECK;
                r.status  = (b == frame_xor) ? hlx_pkg::ST_OK : hlx_pkg::ST_BADSUM;
                r.last    = 1'b1;
                frame_xor = 8'h00;
                body_left = 8'h00;
                phase_q   = PH_HUNT;
            end
        endcase
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!src_gaps || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result checking and sink stalls
    always @(posedge clk)
    begin
        hlx_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result byte %02h role %0d status %0d last %0b",
                         $time, m_axis_tdata, m_axis_tuser[2:0], m_axis_tuser[4:3],
                         m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_axis_tdata !== want.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser[2:0] !== want.role)
                begin
                    $display("%0t: byte_role expected %0d actual %0d",
                             $time, want.role, m_axis_tuser[2:0]);
                    error_count++;
                end
                if (m_axis_tuser[4:3] !== want.status)
                begin
                    $display("%0t: frame_status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser[4:3]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: frame_last expected %0b actual %0b",
                             $time, want.last, m_axis_tlast);
                    error_count++;
                end
                case (want.status)
                    hlx_pkg::ST_OK:     frames_ok++;
                    hlx_pkg::ST_BADSUM: frames_bad_sum++;
                    hlx_pkg::ST_BADLEN: lengths_rejected++;
                    default:   ;
                endcase
            end
        end
        if (ready_hold > 0)
        begin
            ready_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 99) < 20)
        begin
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(parse_byte(b));
        bytes_sent++;
    endtask

    // Hold the source until every outstanding result has been checked
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_register(input logic reg_idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {24'($urandom_range(0, 32'hFFFFFF)), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == hlx_pkg::REG_HEADER)
            cfg_header = value;
        else
            cfg_max_len = value;
    endtask

    task automatic configure(input logic [7:0] hdr, input logic [7:0] max_len);
        wait_for_results();
        // Let the last byte clear both pipeline registers
        repeat (6) @(posedge clk);
        write_register(hlx_pkg::REG_HEADER, hdr);
        write_register(hlx_pkg::REG_MAXLEN, max_len);
        settings_applied++;
    endtask

    task automatic send_frame(input int unsigned len, input bit good_sum);
        logic [7:0] acc;
        logic [7:0] b;
        acc = cfg_header ^ 8'(len);
        send_byte(cfg_header);
        send_byte(8'(len));
        repeat (len)
        begin
            b = ($urandom_range(0, 9) == 0) ? cfg_header : 8'($urandom);
            acc = acc ^ b;
            send_byte(b);
        end
        send_byte(good_sum ? acc : acc ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic test_default_registers();
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'hFE);
    endtask

    task automatic test_length_limits();
        configure(8'hA5, 8'h04);
        // Oversized length that is not the header: back to hunting
        send_byte(8'hA5);
        send_byte(8'h05);
        // Zero length: checksum follows the length directly
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'hA5);
        // Header value in the body, then a wrong checksum
        send_byte(8'hA5);
        send_byte(8'h01);
        send_byte(8'hA5);
        send_byte(8'h00);
    endtask

    task automatic test_rejected_length_restart();
        configure(8'hF0, 8'h00);
        send_byte(8'h80);
        send_byte(8'hF0);
        send_byte(8'hF0);
        send_byte(8'hF0);
        send_byte(8'h00);
        send_byte(8'hF0);
        configure(8'hFF, 8'hFF);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'hFE);
    endtask

    task automatic test_random_traffic();
        logic [7:0]  hdr;
        logic [7:0]  max_len;
        int unsigned target;
        int unsigned kind;
        int unsigned lim;
        for (int phase = 0; phase < 6; phase++)
        begin
            hdr     = 8'($urandom);
            max_len = 8'($urandom);
            case (phase)
                0:
                begin
                    hdr     = 8'h00;
                    max_len = 8'hFF;
                end
                1:
                begin
                    hdr     = 8'hFF;
                    max_len = 8'h00;
                end
                2: max_len = 8'($urandom_range(1, 8));
                4: max_len = 8'hFF;
                5: max_len = 8'($urandom_range(0, 40));
                default: ;
            endcase
            configure(hdr, max_len);
            if (phase == 4)
                send_frame(255, 1'b1);
            target = bytes_sent + 100;
            while (bytes_sent < target)
            begin
                src_gaps    = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
                kind = $urandom_range(0, 99);
                if (kind < 70)
                begin
                    lim = (cfg_max_len < 12) ? cfg_max_len : 12;
                    if ($urandom_range(0, 9) == 0)
                        lim = (cfg_max_len < 60) ? cfg_max_len : 60;
                    send_frame($urandom_range(0, lim), $urandom_range(0, 4) != 0);
                end
                else if (kind < 82)
                begin
                    // Drop the frame with an oversized length where one exists
                    send_byte(cfg_header);
                    if (cfg_max_len != 8'hFF)
                        send_byte(8'($urandom_range(cfg_max_len + 1, 255)));
                    else
                        send_byte(8'($urandom));
                end
                else if (kind < 90)
                begin
                    send_byte(cfg_header);
                    send_byte(cfg_header);
                end
                else
                begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
                if ($urandom_range(0, 99) < 3)
                    wait_for_results();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_registers();
        test_length_limits();
        test_rejected_length_restart();
        test_random_traffic();
        wait_for_results();
        repeat (8) @(posedge clk);
        $display("%0d bytes checked: %0d good frames, %0d checksum errors, %0d rejected lengths",
                 results_checked, frames_ok, frames_bad_sum, lengths_rejected);
        $display("across %0d register settings with random source gaps and sink stalls",
                 settings_applied);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### header_length_xor_frame_parser_unit.f
rtl/core/hlx_pkg.sv
rtl/core/hlx_in_stage.sv
rtl/core/hlx_parser.sv
rtl/core/header_length_xor_frame_parser_unit.sv
dv/testbench.sv
